[design/sprite_frame_sequencer_assert.svh]
// assertion macros shared by the sequencer checks
// each macro samples on clk and is disabled while rst_n is low
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

// condition and consequence in the same cycle
`define SFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite frame sequencer check failed");

// consequence in the cycle after the condition
`define SFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite frame sequencer check failed");

`endif

[design/sfs_pkg.sv]
package sfs_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT   = 3'd4;

    // register widths and reset values
    localparam int FCOUNT_W = 7;
    localparam int COLS_W   = 5;
    localparam int CELL_W   = 10;

    localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 7'd1;
    localparam logic [COLS_W-1:0]   COLUMNS_RST     = 5'd5;

    // item fields
    localparam int IDX_W    = 6;
    localparam int ID_W     = 8;
    localparam int TICKS_W  = 16;
    localparam int ORIGIN_W = 18;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [TICKS_W-1:0] TICKS_MAX = 16'hFFFF;

    // table entry: cell id above duration
    localparam int ENTRY_W = ID_W + TICKS_W;

    // divider runs one quotient bit per cycle
    localparam int DIV_CNT_W = 3;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd7;

    typedef struct packed {
        logic accept;
        logic step;
        logic div_init;
        logic div_step;
        logic mul;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic stop;
        logic steps_done;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

[design/sprite_frame_sequencer.sv]
// channel  | handshake                   | payload
// ---------+-----------------------------+---------------------------------------------
// cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
// item     | item_valid / item_stall     | req_type, entry_index, cell_id, hold_ticks
// result   | result_valid / result_stall | frame_index, origin_x, origin_y, advanced
//
// a tick item first makes s frame steps (at most the frames in use), each a read of the
// frame table and a step; for a load item or after the step bound the current
// entry is read; then the bit-serial cell id divider and the origin multipliers run
// one item is in work at a time; item_stall is high from the cycle after accept
// until the result is loaded into the output register
// the output register lets the next item in while a result waits on result_stall
// rst_n is asynchronous active low; it clears control and config state, not the table
// cfg_ready is always high; configuration must be written only while the block is idle;
// the block itself does not enforce it
module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,

    // item channel
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            req_type,
    input  logic [sfs_pkg::IDX_W-1:0]       entry_index,
    input  logic [sfs_pkg::ID_W-1:0]        cell_id,
    input  logic [sfs_pkg::TICKS_W-1:0]     hold_ticks,

    // result channel
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [sfs_pkg::IDX_W-1:0]       frame_index,
    output logic [sfs_pkg::ORIGIN_W-1:0]    origin_x,
    output logic [sfs_pkg::ORIGIN_W-1:0]    origin_y,
    output logic                            advanced
);

    sfs_pkg::cmd_t    cmd;
    sfs_pkg::status_t status;
    logic             cfg_wr;

    // config is registered on the write, no back pressure
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // controller: accepts items, walks zero-duration runs, sequences divide and multiply
    sfs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .req_type   (req_type),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: config registers, frame table, tick counter, divider,
    // origin multipliers and the result register
    sfs_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .cell_id      (cell_id),
        .hold_ticks   (hold_ticks),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .frame_index  (frame_index),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .advanced     (advanced)
    );

endmodule

[design/sfs_ctrl.sv]
module sfs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            req_type,
    output logic            item_stall,
    input  sfs_pkg::status_t status,
    output sfs_pkg::cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_STEP_RD  = 8'b0000_0010,
        S_STEP     = 8'b0000_0100,
        S_EMIT_RD  = 8'b0000_1000,
        S_DIV_INIT = 8'b0001_0000,
        S_DIV      = 8'b0010_0000,
        S_MUL      = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_type == sfs_pkg::REQ_LOAD)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_STEP_RD;
                    end
                end
            end
            S_STEP_RD:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                // frame entry is unchanged on stop, so its read data is still good
                if (status.stop)
                begin
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (status.steps_done)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_STEP_RD;
                    end
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

[design/sfs_dp.sv]
module sfs_dp #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                req_type,
    input  logic [sfs_pkg::IDX_W-1:0]           entry_index,
    input  logic [sfs_pkg::ID_W-1:0]            cell_id,
    input  logic [sfs_pkg::TICKS_W-1:0]         hold_ticks,
    input  sfs_pkg::cmd_t                       cmd,
    output sfs_pkg::status_t                    status,
    input  logic                                result_stall,
    output logic                                result_valid,
    output logic [sfs_pkg::IDX_W-1:0]           frame_index,
    output logic [sfs_pkg::ORIGIN_W-1:0]        origin_x,
    output logic [sfs_pkg::ORIGIN_W-1:0]        origin_y,
    output logic                                advanced
);

    localparam int PW = $clog2(MAX_FRAMES);
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int PX_W = sfs_pkg::CELL_W + sfs_pkg::COLS_W;
    localparam int PY_W = sfs_pkg::CELL_W + sfs_pkg::ID_W;

    // configuration registers
    logic                           repeat_reg;
    logic [sfs_pkg::FCOUNT_W-1:0]   frame_count_reg;
    logic [sfs_pkg::COLS_W-1:0]     columns_reg;
    logic [sfs_pkg::CELL_W-1:0]     cell_width_reg;
    logic [sfs_pkg::CELL_W-1:0]     cell_height_reg;

    // sequencing state
    logic [PW-1:0]                  cur_reg;
    logic [PW-1:0]                  cur_next;
    logic [sfs_pkg::TICKS_W-1:0]    tick_reg;
    logic [NW-1:0]                  steps_reg;
    logic                           adv_reg;

    // frame table
    logic [sfs_pkg::ENTRY_W-1:0]    table_mem [MAX_FRAMES];
    logic [sfs_pkg::ENTRY_W-1:0]    rdata_reg;
    logic                           wr_en;
    logic [PW-1:0]                  wr_addr;

    // divider and products
    logic [sfs_pkg::ID_W-1:0]       dvd_reg;
    logic [sfs_pkg::COLS_W-1:0]     rem_reg;
    logic [sfs_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [sfs_pkg::COLS_W:0]       trial;
    logic                           qbit;
    logic [sfs_pkg::COLS_W-1:0]     cols_eff;
    logic [PX_W-1:0]                mul_x;
    logic [PY_W-1:0]                mul_y;
    logic [sfs_pkg::ORIGIN_W-1:0]   prod_x_reg;
    logic [sfs_pkg::ORIGIN_W-1:0]   prod_y_reg;

    // output register
    logic                           out_valid_reg;
    logic [sfs_pkg::IDX_W-1:0]      out_frame_reg;
    logic [sfs_pkg::ORIGIN_W-1:0]   out_x_reg;
    logic [sfs_pkg::ORIGIN_W-1:0]   out_y_reg;
    logic                           out_adv_reg;

    logic [NW-1:0]                  n_frames;
    logic [NW:0]                    cur_plus1;
    logic [NW-1:0]                  steps_plus1;
    logic                           is_last;
    logic [sfs_pkg::TICKS_W-1:0]    dur;
    logic                           is_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_reg      <= 1'b0;
            frame_count_reg <= sfs_pkg::FRAME_COUNT_RST;
            columns_reg     <= sfs_pkg::COLUMNS_RST;
            cell_width_reg  <= '0;
            cell_height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sfs_pkg::CFG_REPEAT_MODE:   repeat_reg      <= cfg_data[0];
                sfs_pkg::CFG_FRAME_COUNT:   frame_count_reg <= cfg_data[sfs_pkg::FCOUNT_W-1:0];
                sfs_pkg::CFG_SHEET_COLUMNS: columns_reg     <= cfg_data[sfs_pkg::COLS_W-1:0];
                sfs_pkg::CFG_CELL_WIDTH:    cell_width_reg  <= cfg_data;
                sfs_pkg::CFG_CELL_HEIGHT:   cell_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // frames in use: zero counts as one, saturate at table depth
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            n_frames = NW'(1);
        end
        else if (32'(frame_count_reg) >= MAX_FRAMES)
        begin
            n_frames = NW'(MAX_FRAMES);
        end
        else
        begin
            n_frames = NW'(frame_count_reg);
        end
    end

    assign is_load     = (req_type == sfs_pkg::REQ_LOAD);
    assign cur_plus1   = (NW+1)'(cur_reg) + (NW+1)'(1);
    assign is_last     = (cur_plus1 >= (NW+1)'(n_frames));
    assign steps_plus1 = steps_reg + NW'(1);
    assign dur         = rdata_reg[sfs_pkg::TICKS_W-1:0];
    assign cur_next    = is_last ? '0 : PW'(cur_plus1);

    assign status.stop       = (tick_reg < dur) || (is_last && !repeat_reg);
    assign status.steps_done = (steps_plus1 == n_frames);
    assign status.div_last   = (div_cnt_reg == sfs_pkg::DIV_LAST);
    assign status.out_free   = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            tick_reg  <= '0;
            steps_reg <= '0;
            adv_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            adv_reg   <= 1'b0;
            steps_reg <= '0;
            if (is_load)
            begin
                cur_reg  <= '0;
                tick_reg <= '0;
            end
            else if (tick_reg != sfs_pkg::TICKS_MAX)
            begin
                tick_reg <= tick_reg + 1'b1;
            end
        end
        else if (cmd.step)
        begin
            cur_reg   <= cur_next;
            tick_reg  <= '0;
            adv_reg   <= 1'b1;
            steps_reg <= steps_plus1;
        end
    end

    // loads beyond the table are dropped
    assign wr_en   = cmd.accept && is_load && (32'(entry_index) < MAX_FRAMES);
    assign wr_addr = PW'(entry_index);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= {cell_id, hold_ticks};
        end
        rdata_reg <= table_mem[cur_reg];
    end

    // restoring divide of cell id by column count
    assign cols_eff = (columns_reg == '0) ? sfs_pkg::COLS_W'(1) : columns_reg;
    assign trial    = {rem_reg, dvd_reg[sfs_pkg::ID_W-1]};
    assign qbit     = (trial >= {1'b0, cols_eff});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    assign mul_x = cell_width_reg * rem_reg;
    assign mul_y = cell_height_reg * dvd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            dvd_reg <= rdata_reg[sfs_pkg::ENTRY_W-1:sfs_pkg::TICKS_W];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[sfs_pkg::ID_W-2:0], qbit};
            if (qbit)
            begin
                rem_reg <= sfs_pkg::COLS_W'(trial - {1'b0, cols_eff});
            end
            else
            begin
                rem_reg <= sfs_pkg::COLS_W'(trial);
            end
        end
        if (cmd.mul)
        begin
            prod_x_reg <= sfs_pkg::ORIGIN_W'(mul_x);
            prod_y_reg <= sfs_pkg::ORIGIN_W'(mul_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_frame_reg <= sfs_pkg::IDX_W'(cur_reg);
            out_x_reg     <= prod_x_reg;
            out_y_reg     <= prod_y_reg;
            out_adv_reg   <= adv_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign frame_index  = out_frame_reg;
    assign origin_x     = out_x_reg;
    assign origin_y     = out_y_reg;
    assign advanced     = out_adv_reg;

endmodule

[design/sfs_checker.sv]
`include "sprite_frame_sequencer_assert.svh"

module sfs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_stall,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [sfs_pkg::IDX_W-1:0]     frame_index,
    input logic [sfs_pkg::ORIGIN_W-1:0]  origin_x,
    input logic [sfs_pkg::ORIGIN_W-1:0]  origin_y,
    input logic                          advanced
);

    // an accepted item keeps the block busy in the next cycle
    `SFS_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)

    // a fresh result only appears after the block has been working
    `SFS_ASSERT_NOW(a_result_after_work, $rose(result_valid), $past(item_stall))

    // a held result does not change
    `SFS_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(frame_index) && $stable(origin_x) && $stable(origin_y) && $stable(advanced))

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);
